### src/bilc_pkg.sv
// Package for the battery indicator LED controller.
// Word types, register indexes and the fixed thresholds; no dependencies.
package bilc_pkg;

  typedef struct packed {
    logic [7:0]  charge_status;
    logic [15:0] battery_ocv;
    logic        power_on;
  } in_word_t;

  typedef struct packed {
    logic [6:0] battery_level;
    logic       led_update;
    logic [5:0] led_red;
    logic [6:0] led_green;
    logic       shutdown_request;
  } out_word_t;

  typedef struct packed {
    logic [6:0] low_level_limit;
    logic [7:0] warn_ticks;
  } cfg_t;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegLowLevelLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWarnTicks     = 1'd1;

  localparam logic [6:0] LowLevelLimitRst = 7'd3;
  localparam logic [7:0] WarnTicksRst     = 8'd30;

  localparam logic [15:0] BarThr1 = 16'd4100;
  localparam logic [15:0] BarThr2 = 16'd4800;
  localparam logic [15:0] BarThr3 = 16'd5500;
  localparam logic [15:0] OcvEmpty = 16'd2800;

  // (ocv - 2800) / 27: anything from 2700 up clamps to 100
  localparam logic [15:0] OcvSpanFull = 16'd2700;
  // ceil(2^16 / 27); exact for spans below 3276
  localparam logic [11:0] Recip27 = 12'd2428;

  localparam logic [6:0] LevelMax = 7'd100;
  localparam logic [5:0] RedBlink = 6'd60;
  localparam logic [6:0] GreenFull = 7'd66;
  localparam logic [6:0] GreenRamp1 = 7'd20;
  localparam logic [6:0] GreenRamp2 = 7'd40;
  localparam logic [6:0] GreenRamp3 = 7'd60;

endpackage

### src/bilc_level.sv
// Level decode: bar mask while charging, percentage while discharging.
// Depends on bilc_pkg.
module bilc_level (
  input  logic [15:0] battery_ocv_i,
  output logic [6:0]  bars_o,
  output logic [6:0]  percent_o
);
  import bilc_pkg::*;

  logic [15:0] span;
  logic [23:0] prod;

  always_comb begin
    if (battery_ocv_i < BarThr1) begin
      bars_o = 7'd3;
    end else if (battery_ocv_i < BarThr2) begin
      bars_o = 7'd7;
    end else if (battery_ocv_i < BarThr3) begin
      bars_o = 7'd15;
    end else begin
      bars_o = 7'd31;
    end
  end

  assign span = battery_ocv_i - OcvEmpty;
  // divide by 27 via reciprocal multiply; span is below 2700 here
  assign prod = span[11:0] * Recip27;

  always_comb begin
    if (battery_ocv_i < OcvEmpty) begin
      percent_o = '0;
    end else if (span >= OcvSpanFull) begin
      percent_o = LevelMax;
    end else begin
      percent_o = prod[22:16];
    end
  end

endmodule

### src/bilc_ctrl.sv
// LED and low-power warning control with its tick state.
// Depends on bilc_pkg and bilc_level.
module bilc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bilc_pkg::cfg_t     cfg_i,
  input  bilc_pkg::in_word_t word_i,
  output bilc_pkg::out_word_t word_o
);
  import bilc_pkg::*;

  logic       was_charging_q, was_charging_d;
  logic [2:0] ramp_phase_q, ramp_phase_d;
  logic       blink_on_q, blink_on_d;
  logic [7:0] warn_count_q, warn_count_d;

  logic [6:0] bars, percent;
  logic       charging, full, warn;
  logic [7:0] cnt_inc;

  bilc_level u_level (
    .battery_ocv_i(word_i.battery_ocv),
    .bars_o       (bars),
    .percent_o    (percent)
  );

  assign charging = |word_i.charge_status[7:4];
  assign full     = word_i.charge_status[6];
  assign warn     = (percent <= cfg_i.low_level_limit) && word_i.power_on;
  assign cnt_inc  = (warn_count_q == 8'hFF) ? warn_count_q : warn_count_q + 8'd1;

  always_comb begin
    was_charging_d = was_charging_q;
    ramp_phase_d   = ramp_phase_q;
    blink_on_d     = blink_on_q;
    warn_count_d   = warn_count_q;
    word_o         = '0;
    if (charging) begin
      word_o.battery_level = bars;
      was_charging_d = 1'b1;
      if (full) begin
        word_o.led_update = 1'b1;
        word_o.led_green  = GreenFull;
      end else begin
        warn_count_d = '0;
        ramp_phase_d = ramp_phase_q + 3'd1;
        case (ramp_phase_q)
          3'd1: word_o.led_update = 1'b1;
          3'd2: begin
            word_o.led_update = 1'b1;
            word_o.led_green  = GreenRamp1;
          end
          3'd3: begin
            word_o.led_update = 1'b1;
            word_o.led_green  = GreenRamp2;
          end
          3'd4: begin
            word_o.led_update = 1'b1;
            word_o.led_green  = GreenRamp3;
            ramp_phase_d      = 3'd1;
          end
          default: ;
        endcase
      end
    end else begin
      word_o.battery_level = percent;
      if (was_charging_q) begin
        was_charging_d    = 1'b0;
        word_o.led_update = 1'b1;
      end
      if (warn) begin
        word_o.led_update = 1'b1;
        if (cnt_inc < cfg_i.warn_ticks) begin
          warn_count_d   = cnt_inc;
          blink_on_d     = ~blink_on_q;
          word_o.led_red = blink_on_q ? 6'd0 : RedBlink;
        end else begin
          warn_count_d            = '0;
          word_o.shutdown_request = 1'b1;
        end
      end else begin
        warn_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_charging_q <= 1'b0;
      ramp_phase_q   <= '0;
      blink_on_q     <= 1'b0;
      warn_count_q   <= '0;
    end else if (adv_i) begin
      was_charging_q <= was_charging_d;
      ramp_phase_q   <= ramp_phase_d;
      blink_on_q     <= blink_on_d;
      warn_count_q   <= warn_count_d;
    end
  end

endmodule

### src/battery_indicator_led_controller_unit.sv
// Battery indicator LED controller: one status tick in, one result word out.
// Each word is registered on entry, decoded by a single combinational stage and
// registered again in the output register, and a new word is taken every cycle
// while not stalled; out_stall_i holds both stages. The tick state is updated as
// each word moves to the output. Configuration writes (low-level limit, warning
// tick count) are taken when cfg_we_i is high and should be made with no word
// in flight.
// Depends on bilc_pkg and bilc_ctrl.
module battery_indicator_led_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bilc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bilc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bilc_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bilc_pkg::out_word_t                 out_word_o
);
  import bilc_pkg::*;

  cfg_t      cfg_q;
  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t out_q, res;
  logic      out_valid_q;
  logic      out_free, adv;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign adv        = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_level_limit <= LowLevelLimitRst;
      cfg_q.warn_ticks      <= WarnTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLowLevelLimit: cfg_q.low_level_limit <= cfg_wdata_i[6:0];
        RegWarnTicks:     cfg_q.warn_ticks      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bilc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .cfg_i (cfg_q),
    .word_i(in_q),
    .word_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (~in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
